@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted-array priority queue package
// Shared widths, command and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned CAP_W     = 5;
   localparam int unsigned DEPTH_DEF = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic enq;
      logic live;
      logic at_tail;
   } cell_ctl_type;

endpackage

@@ rtl/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// Sorted-array priority queue request channel
// Valid/ready channel that carries one command and its value.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   data_type           value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);

endinterface

@@ rtl/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Sorted-array priority queue response channel
// Valid/ready channel that carries the status, head value and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if import spq_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   data_type              head_value;
   logic [COUNT_W-1:0]    occupancy;

   modport source (output valid, output status, output head_value, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input head_value, input occupancy,
                   output ready);

endinterface

@@ rtl/sorted_array_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// Sorted-array max-priority queue
// A row of cells, largest value at the head; an enqueue inserts by shifting
// every smaller live entry one cell toward the tail.
//
//   Channel   Direction   Transfer carries
//   req_if    in          cmd, value
//   rsp_if    out         status, head_value, occupancy
//   csr       in          capacity (write only)
//
// The cell row compares all slots at once.
// A new request is taken while the previous response is being transferred.
// The response register holds its result until the sink takes it, and no
// request is taken meanwhile. Reset empties the queue.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core import spq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   spq_req_if.sink            req_if,
   spq_rsp_if.source          rsp_if,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

   logic [CAP_W-1:0]    capacity_ff;
   logic [IW-1:0]       head_ff, head_in;
   logic [CW-1:0]       tail_ff, tail_in;
   logic                empty_ff, empty_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                accept;
   logic [EW-1:0]       cap_ext;
   logic [EW-1:0]       eff_cap;
   logic                full;
   logic                enq_go;
   logic [CW-1:0]       head_inc;

   data_type            slot_w [DEPTH];
   logic                lt_w   [DEPTH];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign cap_ext = EW'(capacity_ff);

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full     = EW'(tail_ff) >= eff_cap;
   assign enq_go   = accept && (req_if.cmd == CMD_ENQ) && !full;
   assign head_inc = CW'(head_ff) + CW'(1);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam logic [CW-1:0] POS = CW'(g);
      cell_ctl_type ctl;
      data_type     left_slot;
      logic         left_lt;

      assign ctl = '{
         enq:     enq_go,
         live:    !empty_ff && (POS >= CW'(head_ff)) && (POS < tail_ff),
         at_tail: (POS == tail_ff)
      };

      if (g == 0) begin : g_first
         assign left_slot = '0;
         assign left_lt   = 1'b0;
      end else begin : g_rest
         assign left_slot = slot_w[g-1];
         assign left_lt   = lt_w[g-1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_value (req_if.value),
         .left_slot (left_slot),
         .left_lt   (left_lt),
         .slot      (slot_w[g]),
         .lt        (lt_w[g])
      );
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_if.cmd)
            CMD_ENQ: begin
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  status_in = ST_OK;
                  empty_in  = 1'b0;
                  tail_in   = tail_ff + CW'(1);
               end
            end
            CMD_DEQ: begin
               if (empty_ff) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_OK;
                  if (head_inc >= tail_ff) begin
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     head_in = IW'(head_inc);
                  end
               end
            end
            default: begin
               status_in = empty_ff ? ST_EMPTY : ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.head_value = empty_ff ? '1 : slot_w[head_ff];
   assign rsp_if.occupancy  = COUNT_W'(tail_ff - CW'(head_ff));

endmodule

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted-array priority queue cell
// Holds one slot. On an insert it either keeps its value, takes the value of
// its left neighbor, or takes the new value, so the row stays sorted.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  data_type      new_value,
   input  data_type      left_slot,
   input  logic          left_lt,
   output data_type      slot,
   output logic          lt
);

   data_type slot_ff;
   data_type slot_in;
   logic     write;

   assign lt    = ctl.live && (slot_ff < new_value);
   assign write = ctl.enq && (lt || ctl.at_tail);
   assign slot  = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (write) begin
         slot_in = left_lt ? left_slot : new_value;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
